// ----- design/sqd_pkg.sv -----
// Shared types, constants and codes of the shortest-queue dispatcher.
package sqd_pkg;

	localparam int MAX_SERVERS_DEF = 4;
	localparam int QUEUE_DEPTH_DEF = 3;
	localparam int JOBQ_DEPTH_LOG2 = 1;
	localparam int RPTQ_DEPTH_LOG2 = 2;

	localparam logic [1:0] KIND_ABORT  = 2'd0;
	localparam logic [1:0] KIND_LATE   = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	typedef struct packed {
		logic [15:0] job_id;
		logic [19:0] arrival_time;
		logic [15:0] service_time;
		logic [20:0] deadline_time;
		logic        end_of_stream;
	} job_t;

	typedef struct packed {
		job_t job;
		logic drop;
	} qjob_t;

	typedef struct packed {
		logic [1:0]  report_kind;
		logic [15:0] report_job;
		logic [2:0]  report_server;
		logic [23:0] event_tick;
		logic [23:0] wait_ticks;
		logic        last_report;
	} report_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_PLACE,
		ST_SHORT,
		ST_DECIDE,
		ST_EOS,
		ST_FINISH
	} seq_state_t;

endpackage

// ----- design/sqd_fifo.sv -----
// Small register FIFO with push/full and pop/empty sides.
module sqd_fifo #(
	parameter int WIDTH      = 8,
	parameter int DEPTH_LOG2 = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] dout
);
	localparam int DEPTH = 1 << DEPTH_LOG2;

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [DEPTH_LOG2:0] wr_q, rd_q;

	assign empty = (wr_q == rd_q);
	assign full  = (wr_q[DEPTH_LOG2] != rd_q[DEPTH_LOG2]) &&
		(wr_q[DEPTH_LOG2-1:0] == rd_q[DEPTH_LOG2-1:0]);
	assign dout  = mem_q[rd_q[DEPTH_LOG2-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push && !full) wr_q <= wr_q + 1'b1;
			if (pop && !empty) rd_q <= rd_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q[DEPTH_LOG2-1:0]] <= din;
	end

endmodule

// ----- design/sqd_front.sv -----
// Front end: accepts jobs, flags hopeless ones, buffers them for the sequencer.
module sqd_front import sqd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  job_t  job,
	input  logic  jq_pop,
	output logic  jq_empty,
	output qjob_t jq_data
);
	qjob_t     entry;
	logic [20:0] fin_min;

	// earliest possible completion; a job past its deadline even then is dropped
	assign fin_min     = {1'b0, job.arrival_time} + 21'(job.service_time);
	assign entry.job   = job;
	assign entry.drop  = (job.deadline_time < {1'b0, job.arrival_time}) ||
		(job.deadline_time < fin_min);

	sqd_fifo #(
		.WIDTH      ($bits(qjob_t)),
		.DEPTH_LOG2 (JOBQ_DEPTH_LOG2)
	) u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.din    (entry),
		.pop    (jq_pop),
		.empty  (jq_empty),
		.dout   (jq_data)
	);

endmodule

// ----- design/sqd_back.sv -----
// Back end: per-server state, per-server job FIFOs and the dispatch sequencer.
module sqd_back import sqd_pkg::*; #(
	parameter int MAX_SERVERS = MAX_SERVERS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_data,
	input  logic       jq_empty,
	input  qjob_t      jq_data,
	output logic       jq_pop,
	output logic       rpt_push,
	input  logic       rpt_full,
	output report_t    rpt_data
);
	localparam int SRV_W  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int SCN_W  = $clog2(MAX_SERVERS + 1);
	localparam int HEAD_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int SLOTS  = MAX_SERVERS * QUEUE_DEPTH;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	function automatic logic [23:0] sat_add(input logic [23:0] a, input logic [23:0] b);
		logic [24:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[24] ? 24'hFFFFFF : s[23:0];
	endfunction

	seq_state_t st_q, st_d;
	logic [2:0]       cfg_q;
	logic [SCN_W-1:0] active, c_q;
	logic [SRV_W-1:0] ci, best_q;
	logic [23:0]      busy_q [MAX_SERVERS];
	logic [CNT_W-1:0] cnt_q  [MAX_SERVERS];
	logic [HEAD_W-1:0] head_q [MAX_SERVERS];
	logic [15:0] q_id_q  [SLOTS];
	logic [19:0] q_arr_q [SLOTS];
	logic [15:0] q_svc_q [SLOTS];
	logic [20:0] q_dl_q  [SLOTS];
	qjob_t       job_q;
	report_t     held_q, rep_new;
	logic        held_v_q;

	logic go, at_end, serve, do_place, do_enq, emit;
	logic c_inc, c_clr, c_one, best_upd, ld_job;
	logic [SLOT_W-1:0] hslot, eslot;
	logic [23:0] arr24, start, fin, pfin, hwait;
	logic        abort, late, plate;
	logic [HEAD_W-1:0] head_nxt, tpos;
	logic [HEAD_W:0]   tsum;

	always_comb begin
		if (cfg_q == 3'd0)                 active = SCN_W'(1);
		else if (int'(cfg_q) > MAX_SERVERS) active = SCN_W'(MAX_SERVERS);
		else                                active = SCN_W'(cfg_q);
	end

	assign ci     = c_q[SRV_W-1:0];
	assign at_end = (c_q >= active);
	assign go     = !rpt_full;
	assign arr24  = {4'd0, job_q.job.arrival_time};

	// head of the scanned server's queue
	assign hslot = SLOT_W'(int'(ci) * QUEUE_DEPTH + int'(head_q[ci]));
	assign start = busy_q[ci];
	assign abort = {3'd0, q_dl_q[hslot]} < start;
	assign fin   = sat_add(start, {8'd0, q_svc_q[hslot]});
	assign late  = {3'd0, q_dl_q[hslot]} < fin;
	assign hwait = (start > {4'd0, q_arr_q[hslot]}) ? start - {4'd0, q_arr_q[hslot]} : '0;
	assign head_nxt = (int'(head_q[ci]) + 1 >= QUEUE_DEPTH) ? '0 : head_q[ci] + 1'b1;

	// new job started at once
	assign pfin  = sat_add(arr24, {8'd0, job_q.job.service_time});
	assign plate = {3'd0, job_q.job.deadline_time} < pfin;

	// tail slot of the chosen queue
	assign tsum  = {1'b0, head_q[best_q]} + (HEAD_W+1)'(cnt_q[best_q]);
	assign tpos  = (int'(tsum) >= QUEUE_DEPTH) ? HEAD_W'(int'(tsum) - QUEUE_DEPTH) :
		tsum[HEAD_W-1:0];
	assign eslot = SLOT_W'(int'(best_q) * QUEUE_DEPTH + int'(tpos));

	always_comb begin
		st_d     = st_q;
		serve    = 1'b0;
		do_place = 1'b0;
		do_enq   = 1'b0;
		emit     = 1'b0;
		c_inc    = 1'b0;
		c_clr    = 1'b0;
		c_one    = 1'b0;
		best_upd = 1'b0;
		ld_job   = 1'b0;
		rep_new  = '0;
		rep_new.report_job    = q_id_q[hslot];
		rep_new.report_server = 3'(int'(ci) + 1);
		rep_new.wait_ticks    = hwait;
		if (abort) begin
			rep_new.report_kind = KIND_ABORT;
			rep_new.event_tick  = start;
		end else begin
			rep_new.report_kind = KIND_LATE;
			rep_new.event_tick  = fin;
		end
		case (st_q)
			ST_IDLE: begin
				if (!jq_empty) begin
					ld_job = 1'b1;
					c_clr  = 1'b1;
					st_d   = jq_data.drop ? ST_EOS : ST_DRAIN;
				end
			end
			ST_DRAIN: if (go) begin
				if (at_end) begin
					c_clr = 1'b1;
					st_d  = ST_PLACE;
				end else if (cnt_q[ci] != '0 && busy_q[ci] <= arr24) begin
					serve = 1'b1;
					emit  = abort || late;
				end else begin
					c_inc = 1'b1;
				end
			end
			ST_PLACE: if (go) begin
				if (at_end) begin
					c_one = 1'b1;
					st_d  = ST_SHORT;
				end else if (busy_q[ci] <= arr24) begin
					do_place = 1'b1;
					emit     = plate;
					rep_new.report_kind = KIND_LATE;
					rep_new.report_job  = job_q.job.job_id;
					rep_new.event_tick  = pfin;
					rep_new.wait_ticks  = '0;
					c_clr = 1'b1;
					st_d  = ST_EOS;
				end else begin
					c_inc = 1'b1;
				end
			end
			ST_SHORT: begin
				if (at_end) begin
					st_d = ST_DECIDE;
				end else begin
					best_upd = (cnt_q[ci] < cnt_q[best_q]);
					c_inc    = 1'b1;
				end
			end
			ST_DECIDE: if (go) begin
				if (int'(cnt_q[best_q]) >= QUEUE_DEPTH) begin
					emit = 1'b1;
					rep_new.report_kind   = KIND_REJECT;
					rep_new.report_job    = job_q.job.job_id;
					rep_new.report_server = '0;
					rep_new.event_tick    = arr24;
					rep_new.wait_ticks    = '0;
				end else begin
					do_enq = 1'b1;
				end
				c_clr = 1'b1;
				st_d  = ST_EOS;
			end
			ST_EOS: if (go) begin
				if (!job_q.job.end_of_stream || at_end) begin
					st_d = ST_FINISH;
				end else if (cnt_q[ci] != '0) begin
					serve = 1'b1;
					emit  = abort || late;
				end else begin
					c_inc = 1'b1;
				end
			end
			ST_FINISH: if (go) begin
				st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	assign jq_pop   = ld_job;
	// one report is held back so the last one of a job can be flagged
	assign rpt_push = go && held_v_q && (emit || st_q == ST_FINISH);
	always_comb begin
		rpt_data = held_q;
		rpt_data.last_report = (st_q == ST_FINISH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			cfg_q    <= 3'd1;
			c_q      <= '0;
			best_q   <= '0;
			held_v_q <= 1'b0;
			for (int i = 0; i < MAX_SERVERS; i++) begin
				busy_q[i] <= '0;
				cnt_q[i]  <= '0;
				head_q[i] <= '0;
			end
		end else begin
			st_q <= st_d;
			if (cfg_we) cfg_q <= cfg_data;
			if (c_clr)      c_q <= '0;
			else if (c_one) c_q <= SCN_W'(1);
			else if (c_inc) c_q <= c_q + 1'b1;
			if (c_one)         best_q <= '0;
			else if (best_upd) best_q <= ci;
			if (emit)                             held_v_q <= 1'b1;
			else if (st_q == ST_FINISH && go)     held_v_q <= 1'b0;
			if (serve) begin
				head_q[ci] <= head_nxt;
				cnt_q[ci]  <= cnt_q[ci] - 1'b1;
				if (!abort) busy_q[ci] <= fin;
			end
			if (do_place) busy_q[ci] <= pfin;
			if (do_enq) cnt_q[best_q] <= cnt_q[best_q] + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_job) job_q <= jq_data;
		if (emit) held_q <= rep_new;
		if (do_enq) begin
			q_id_q[eslot]  <= job_q.job.job_id;
			q_arr_q[eslot] <= job_q.job.arrival_time;
			q_svc_q[eslot] <= job_q.job.service_time;
			q_dl_q[eslot]  <= job_q.job.deadline_time;
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_push |-> !rpt_full) else $error("report pushed into full queue");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q[0]) <= QUEUE_DEPTH) else $error("server queue overfilled");
	a_busy_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> busy_q[0] >= $past(busy_q[0])) else $error("busy time went back");
	a_finish_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FINISH && go) |=> !held_v_q && st_q == ST_IDLE)
		else $error("held report not flushed at job end");
`endif

endmodule

// ----- design/shortest_queue_dispatcher.sv -----
// Top level of the join-shortest-queue job dispatcher with deadlines.
//
// Usage:
//   Jobs enter on the job port: a transaction completes when push is high and
//   full is low. Reports leave on the report port: while empty is low the
//   oldest report is shown, and pop high takes it. cfg_we writes server_count
//   (0 acts as 1, values above MAX_SERVERS act as MAX_SERVERS); write it only
//   while no job is in flight.
// Flow:
//   A job goes through a two-entry input queue into a sequencer that works on
//   one job at a time. The sequencer scans the servers one per cycle while the
//   report queue has room: it serves due queued jobs, places the job on a free
//   server, else enqueues it on the shortest queue or rejects it, and with
//   end_of_stream set drains every queue; each served job gives at most one
//   report. A dropped job goes straight to the final drain. A report is held
//   until the job's next report or its last cycle, then enters the report queue.
// Reset: all servers free, all queues empty, server_count = 1.
// Stall: while the four-entry report queue is full the sequencer holds but in
//   idle and the queue scan; the input queue takes jobs until full rises.
module shortest_queue_dispatcher import sqd_pkg::*; #(
	parameter int MAX_SERVERS = MAX_SERVERS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  job_t       job,
	input  logic       pop,
	output logic       empty,
	output report_t    report,
	input  logic       cfg_we,
	input  logic [2:0] cfg_data
);
	logic    jq_pop, jq_empty;
	qjob_t   jq_data;
	logic    rpt_push, rpt_full;
	report_t rpt_data;

	// front: job intake and deadline screen
	sqd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.job      (job),
		.jq_pop   (jq_pop),
		.jq_empty (jq_empty),
		.jq_data  (jq_data)
	);

	// back: drain, place, enqueue or reject, final drain
	sqd_back #(
		.MAX_SERVERS (MAX_SERVERS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.jq_empty (jq_empty),
		.jq_data  (jq_data),
		.jq_pop   (jq_pop),
		.rpt_push (rpt_push),
		.rpt_full (rpt_full),
		.rpt_data (rpt_data)
	);

	// report queue decouples the sequencer from the consumer
	sqd_fifo #(
		.WIDTH      ($bits(report_t)),
		.DEPTH_LOG2 (RPTQ_DEPTH_LOG2)
	) u_rptq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rpt_push),
		.full   (rpt_full),
		.din    (rpt_data),
		.pop    (pop),
		.empty  (empty),
		.dout   (report)
	);

endmodule
